// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the recorder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsr checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsr checker: next-cycle property failed");

`endif

// File: src/dsr_pkg.sv
// ----------------------------------------------------------------------------
// dsr_pkg
// Widths, field positions, opcodes and sequencer states of the recorder.
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int DEFAULT_CAPACITY = 256;

  localparam int OPCODE_W   = 2;
  localparam int TIME_W     = 48;
  localparam int VALUE_W    = 32;
  localparam int INTERVAL_W = 40;
  localparam int COUNT_W    = 9;
  localparam int INDEX_W    = 8;
  localparam int ENTRY_W    = TIME_W + VALUE_W + 1;

  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 136;

  // Input beat field positions.
  localparam int IN_TIME_LSB   = 0;
  localparam int IN_VALUE_LSB  = 48;
  localparam int IN_USABLE_BIT = 80;
  localparam int IN_INDEX_LSB  = 81;

  // Output beat field positions.
  localparam int OUT_ACC_BIT    = 0;
  localparam int OUT_DEC_BIT    = 1;
  localparam int OUT_CNT_LSB    = 2;
  localparam int OUT_INT_LSB    = 11;
  localparam int OUT_RT_LSB     = 51;
  localparam int OUT_RV_LSB     = 99;
  localparam int OUT_RU_BIT     = 131;
  localparam int OUT_RVALID_BIT = 132;

  localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 40'd20000;

  localparam logic [OPCODE_W-1:0] OP_RECORD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RESTART = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_READ_DATA,
    ST_DEC_RD,
    ST_DEC_WR,
    ST_APPEND,
    ST_RESULT
  } dsr_state_t;

endpackage

// File: src/decimating_sample_recorder.sv
// ----------------------------------------------------------------------------
// decimating_sample_recorder
// Timestamped sample store that halves itself in place when it fills up.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Contents
//  --------+-----------+----------------------+---------------------------------
//  s_      | in        | s_tvalid / s_tready  | opcode in tuser, sample in tdata
//  m_      | out       | m_tvalid / m_tready  | one result beat per input beat
//  cfg_    | in        | cfg_valid/cfg_ready  | initial_interval write data
//
//  One beat at a time, stepping through EVAL, then APPEND for a stored sample
//  or READ and READ_DATA for an in-range read, then RESULT. A full store
//  is halved first, through the memory port, DEC_RD then DEC_WR per entry.
//  Synchronous reset clears count and newest time and presets spacing, not
//  the memory; entries are only read below the count. A stalled result waits
//  in the output register while the next beat is taken, and the next one waits.
// ----------------------------------------------------------------------------
module decimating_sample_recorder
  import dsr_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input beat.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // tdata from bit 0: sample_time[48], sample_value[32], sample_usable[1],
  // read_index[8], zero fill[7].
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // tuser: opcode[2].
  input  logic [OPCODE_W-1:0]    s_tuser,
  // Result beat.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // tdata from bit 0: accepted[1], decimated[1], entry_count[9],
  // current_interval[40], read_time[48], read_value[32], read_usable[1],
  // read_valid[1], zero fill[3].
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // Configuration write.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [INTERVAL_W-1:0]  cfg_data
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int HALF   = CAPACITY / 2;

  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(HALF);
  localparam logic [IDX_W-1:0] DEC_LAST = IDX_W'(HALF - 1);

  // Sequencer and architectural state.
  dsr_state_t              state, state_next;
  logic [CNT_W-1:0]        fill_count, fill_count_next;
  logic [INTERVAL_W-1:0]   spacing, spacing_next;
  logic [TIME_W-1:0]       newest_time, newest_time_next;
  logic [INTERVAL_W-1:0]   init_interval;

  // Latched input beat.
  logic [OPCODE_W-1:0]     in_op, in_op_next;
  logic [TIME_W-1:0]       in_time, in_time_next;
  logic [VALUE_W-1:0]      in_value, in_value_next;
  logic                    in_usable, in_usable_next;
  logic [INDEX_W-1:0]      in_index, in_index_next;

  // Result under construction.
  logic                    res_acc, res_acc_next;
  logic                    res_dec, res_dec_next;
  logic [TIME_W-1:0]       res_time, res_time_next;
  logic [VALUE_W-1:0]      res_value, res_value_next;
  logic                    res_usable, res_usable_next;
  logic                    res_valid, res_valid_next;

  // Decimation walk position.
  logic [IDX_W-1:0]        dec_idx, dec_idx_next;

  // Output register.
  logic                    m_tvalid_next;
  logic [OUT_TDATA_W-1:0]  m_tdata_next;

  // Memory port.
  logic [ENTRY_W-1:0]      store [CAPACITY];
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [IDX_W-1:0]        mem_raddr;
  logic [ENTRY_W-1:0]      mem_wdata;
  logic [ENTRY_W-1:0]      mem_rdata;

  // Derived values.
  logic [TIME_W:0]         time_diff;
  logic                    take;
  logic [EXT_W-1:0]        cnt_ext;
  logic [EXT_W-1:0]        idx_ext;
  logic                    rd_ok;
  logic [INTERVAL_W-1:0]   spacing_dbl;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Spacing check against the newest stored time.
  assign time_diff = {1'b0, in_time} - {1'b0, newest_time};
  assign take = (fill_count == '0) ||
                (!time_diff[TIME_W] && (time_diff[TIME_W-1:0] != '0) &&
                 (time_diff[TIME_W-1:0] >= TIME_W'(spacing)));

  // Read index range check.
  assign cnt_ext = EXT_W'(fill_count);
  assign idx_ext = EXT_W'(in_index);
  assign rd_ok   = (idx_ext < cnt_ext);

  // Doubling with saturation at the top of the interval range.
  assign spacing_dbl = spacing[INTERVAL_W-1] ? '1 : {spacing[INTERVAL_W-2:0], 1'b0};

  // Sample store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= store[mem_raddr];
  end

  // Next state, memory control and result assembly.
  always_comb begin
    state_next       = state;
    fill_count_next  = fill_count;
    spacing_next     = spacing;
    newest_time_next = newest_time;
    in_op_next       = in_op;
    in_time_next     = in_time;
    in_value_next    = in_value;
    in_usable_next   = in_usable;
    in_index_next    = in_index;
    res_acc_next     = res_acc;
    res_dec_next     = res_dec;
    res_time_next    = res_time;
    res_value_next   = res_value;
    res_usable_next  = res_usable;
    res_valid_next   = res_valid;
    dec_idx_next     = dec_idx;
    m_tvalid_next    = m_tvalid && !m_tready;
    m_tdata_next     = m_tdata;
    mem_we           = 1'b0;
    mem_waddr        = fill_count[IDX_W-1:0];
    mem_wdata        = {in_usable, in_value, in_time};
    mem_raddr        = idx_ext[IDX_W-1:0];

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          in_op_next     = s_tuser;
          in_time_next   = s_tdata[IN_TIME_LSB +: TIME_W];
          in_value_next  = s_tdata[IN_VALUE_LSB +: VALUE_W];
          in_usable_next = s_tdata[IN_USABLE_BIT];
          in_index_next  = s_tdata[IN_INDEX_LSB +: INDEX_W];
          state_next     = ST_EVAL;
        end
      end
      ST_EVAL: begin
        res_acc_next    = 1'b0;
        res_dec_next    = 1'b0;
        res_time_next   = '0;
        res_value_next  = '0;
        res_usable_next = 1'b0;
        res_valid_next  = 1'b0;
        state_next      = ST_RESULT;
        case (in_op)
          OP_RECORD: begin
            if (take) begin
              if (fill_count >= CAP_CNT) begin
                dec_idx_next = IDX_W'(1);
                state_next   = ST_DEC_RD;
              end else begin
                state_next = ST_APPEND;
              end
            end
          end
          OP_RESTART: begin
            fill_count_next = '0;
            spacing_next    = init_interval;
          end
          OP_READ: begin
            if (rd_ok) begin
              state_next = ST_READ;
            end
          end
          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end
      ST_READ: begin
        state_next = ST_READ_DATA;
      end
      ST_READ_DATA: begin
        res_time_next   = mem_rdata[TIME_W-1:0];
        res_value_next  = mem_rdata[TIME_W +: VALUE_W];
        res_usable_next = mem_rdata[ENTRY_W-1];
        res_valid_next  = 1'b1;
        state_next      = ST_RESULT;
      end
      ST_DEC_RD: begin
        // Entry 2*i is read; entry i is written next cycle.
        mem_raddr  = IDX_W'({dec_idx, 1'b0});
        state_next = ST_DEC_WR;
      end
      ST_DEC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dec_idx;
        mem_wdata = mem_rdata;
        if (dec_idx == DEC_LAST) begin
          fill_count_next = HALF_CNT;
          spacing_next    = spacing_dbl;
          res_dec_next    = 1'b1;
          state_next      = ST_APPEND;
        end else begin
          dec_idx_next = dec_idx + IDX_W'(1);
          state_next   = ST_DEC_RD;
        end
      end
      ST_APPEND: begin
        mem_we           = 1'b1;
        newest_time_next = in_time;
        fill_count_next  = fill_count + CNT_W'(1);
        res_acc_next     = 1'b1;
        state_next       = ST_RESULT;
      end
      ST_RESULT: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {3'b000, res_valid, res_usable, res_value, res_time,
                           spacing, cnt_ext[COUNT_W-1:0], res_dec, res_acc};
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill_count  <= '0;
      spacing     <= RESET_INTERVAL;
      newest_time <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      fill_count  <= fill_count_next;
      spacing     <= spacing_next;
      newest_time <= newest_time_next;
      m_tvalid    <= m_tvalid_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_interval <= RESET_INTERVAL;
    end else if (cfg_valid) begin
      init_interval <= cfg_data;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    in_op      <= in_op_next;
    in_time    <= in_time_next;
    in_value   <= in_value_next;
    in_usable  <= in_usable_next;
    in_index   <= in_index_next;
    res_acc    <= res_acc_next;
    res_dec    <= res_dec_next;
    res_time   <= res_time_next;
    res_value  <= res_value_next;
    res_usable <= res_usable_next;
    res_valid  <= res_valid_next;
    dec_idx    <= dec_idx_next;
    m_tdata    <= m_tdata_next;
  end

endmodule

// File: src/dsr_checker.sv
// ----------------------------------------------------------------------------
// dsr_checker
// Port-level checks on the recorder result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsr_checker
  import dsr_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam logic [COUNT_W-1:0] DEC_COUNT = COUNT_W'((CAPACITY / 2 + 1) % 512);
  localparam bit                 WIDE_CAP  = (CAPACITY > 511);

  logic                 o_acc;
  logic                 o_dec;
  logic [COUNT_W-1:0]   o_cnt;
  logic                 o_rvalid;
  logic                 o_ru;
  logic [TIME_W-1:0]    o_rt;
  logic [VALUE_W-1:0]   o_rv;

  assign o_acc    = m_tdata[OUT_ACC_BIT];
  assign o_dec    = m_tdata[OUT_DEC_BIT];
  assign o_cnt    = m_tdata[OUT_CNT_LSB +: COUNT_W];
  assign o_rvalid = m_tdata[OUT_RVALID_BIT];
  assign o_ru     = m_tdata[OUT_RU_BIT];
  assign o_rt     = m_tdata[OUT_RT_LSB +: TIME_W];
  assign o_rv     = m_tdata[OUT_RV_LSB +: VALUE_W];

  // A stalled result beat holds.
  `ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // The reported count never exceeds the store size (unchecked above 511 entries).
  `ASSERT_IMPLIES(a_count, clk, rst, m_tvalid, WIDE_CAP || (32'(o_cnt) <= 32'(CAPACITY)))

  // Read fields are zero unless the read hit a held entry.
  `ASSERT_IMPLIES(a_rd_zero, clk, rst, m_tvalid && !o_rvalid,
                  (o_rt == '0) && (o_rv == '0) && !o_ru)

  // A halving pass always ends with the new sample appended to half a store.
  `ASSERT_IMPLIES(a_dec, clk, rst, m_tvalid && o_dec,
                  o_acc && !o_rvalid && (o_cnt == DEC_COUNT))

endmodule

bind decimating_sample_recorder dsr_checker #(.CAPACITY(CAPACITY)) u_dsr_checker (.*);
